FILE: rtl/spt_pkg.sv
// shared types, codes and helpers for the sparse polynomial term merger
`timescale 1ns / 1ps

package spt_pkg;

   localparam int MAX_TERMS_DEFAULT = 32;
   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_ADD    = 2'd1,
      OP_EMIT   = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_DROPPED  = 2'd1,
      STATUS_EMITTED  = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_EXEC,
      STATE_DRAIN
   } state_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] coef;
      logic signed [WORD_W-1:0] expo;
   } term_type;

   // what every cell does in this cycle
   typedef struct packed {
      logic insert;
      logic merge;
      logic drain;
   } cell_cmd_type;

   // what a cell tells its right-hand neighbor
   typedef struct packed {
      logic eq;
      logic move;
   } cell_flags_type;

   function automatic logic signed [WORD_W-1:0] sat_add(
      input logic signed [WORD_W-1:0] a,
      input logic signed [WORD_W-1:0] b
   );
      logic signed [WORD_W:0] sum;
      logic signed [WORD_W-1:0] res;
      sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (sum[WORD_W] != sum[WORD_W-1]) begin
         res = sum[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         res = sum[WORD_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/spt_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface spt_req_if;
   logic                      valid;
   logic                      ready;
   spt_pkg::opcode_type       opcode;
   logic signed [31:0]        coefficient;
   logic signed [31:0]        exponent;

   modport source (output valid, output opcode, output coefficient, output exponent,
                   input ready);
   modport sink (input valid, input opcode, input coefficient, input exponent,
                 output ready);
endinterface

interface spt_rsp_if;
   logic                      valid;
   logic                      ready;
   spt_pkg::status_type       status;
   logic signed [31:0]        term_coefficient;
   logic signed [31:0]        term_exponent;
   logic                      last;

   modport source (output valid, output status, output term_coefficient,
                   output term_exponent, output last, input ready);
   modport sink (input valid, input status, input term_coefficient,
                 input term_exponent, input last, output ready);
endinterface

FILE: rtl/spt_cell.sv
// one cell of the sorted term chain: holds a term, inserts, merges and shifts
`timescale 1ns / 1ps

module spt_cell (
   input  logic                    clock,
   input  spt_pkg::cell_cmd_type   cmd,
   input  spt_pkg::term_type       new_term,
   input  logic                    valid,
   input  spt_pkg::cell_flags_type prev_flags,
   input  spt_pkg::term_type       prev_term,
   input  spt_pkg::term_type       next_term,
   output spt_pkg::cell_flags_type flags,
   output spt_pkg::term_type       term
);
   import spt_pkg::*;

   term_type term_ff;
   term_type term_in;

   // chain stays sorted by exponent descending, equal exponents in arrival order
   assign flags.eq   = valid && (term_ff.expo == new_term.expo);
   assign flags.move = !(valid && (term_ff.expo >= new_term.expo));
   assign term       = term_ff;

   always_comb begin
      term_in = term_ff;
      if (cmd.drain) begin
         term_in = next_term;
      end else if (cmd.insert) begin
         if (flags.move && prev_flags.move) begin
            term_in = prev_term;
         end else if (flags.move) begin
            term_in = new_term;
         end
      end else if (cmd.merge && flags.eq && !prev_flags.eq) begin
         // only the earliest entry with this exponent takes the sum
         term_in.coef = sat_add(term_ff.coef, new_term.coef);
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
   end

endmodule

FILE: rtl/sparse_polynomial_term_merger_unit.sv
// top level of the sparse polynomial term merger: control and cell chain
//
// Usage:
//   req_ch carries one item per valid/ready handshake: opcode, coefficient and
//   exponent. Append puts a term into the table, add merges it into the entry
//   of equal exponent (saturating) or puts it in, emit streams every stored
//   term by descending exponent (ties in arrival order) and clears the table.
//   rsp_ch returns status, term_coefficient, term_exponent and last.
//   Append and add give one response each; with a full table, a term that
//   needs a new entry is dropped with the dropped status. Emit gives one
//   response per stored term, one per cycle while the receiver does not
//   stall, the final one marked last; an empty table gives a single empty
//   status. Opcode 3 gives no response. An item passes the command stage, where
//   the cell chain inserts or merges it; new requests wait until idle again.
//   The chain of MAX_TERMS cells compares every stored exponent in parallel and
//   shifts to make room, so the table is always kept sorted.
//   Reset clears the state, fill count and response valid; stored terms are
//   not cleared. When the receiver stalls, the response register holds and the
//   block waits before the next step.
`timescale 1ns / 1ps

module sparse_polynomial_term_merger_unit #(
   parameter int MAX_TERMS = spt_pkg::MAX_TERMS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   spt_req_if.sink       req_ch,
   spt_rsp_if.source     rsp_ch
);
   import spt_pkg::*;

   localparam int CW = $clog2(MAX_TERMS + 1);

   state_type        state_ff, state_in;
   opcode_type       op_ff;
   term_type         item_ff;
   logic [CW-1:0]    count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   term_type         rsp_term_ff, rsp_term_in;
   logic             rsp_last_ff, rsp_last_in;

   cell_cmd_type     cmd;
   cell_flags_type   flags [MAX_TERMS];
   term_type         terms [MAX_TERMS];
   logic [MAX_TERMS-1:0] eq_vec;
   logic             any_eq;
   logic             full;
   logic             slot_free;
   logic             needs_entry;

   genvar i;
   generate
      for (i = 0; i < MAX_TERMS; i++) begin : g_cell
         cell_flags_type prev_flags;
         term_type       prev_term;
         term_type       next_term;
         if (i == 0) begin : g_head
            assign prev_flags = '0;
            assign prev_term  = '0;
         end else begin : g_body
            assign prev_flags = flags[i-1];
            assign prev_term  = terms[i-1];
         end
         if (i == MAX_TERMS - 1) begin : g_tail
            assign next_term = '0;
         end else begin : g_inner
            assign next_term = terms[i+1];
         end
         spt_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .new_term   (item_ff),
            .valid      (CW'(i) < count_ff),
            .prev_flags (prev_flags),
            .prev_term  (prev_term),
            .next_term  (next_term),
            .flags      (flags[i]),
            .term       (terms[i])
         );
         assign eq_vec[i] = flags[i].eq;
      end
   endgenerate

   assign any_eq      = |eq_vec;
   assign full        = (count_ff == CW'(MAX_TERMS));
   assign slot_free   = !rsp_valid_ff || rsp_ch.ready;
   assign needs_entry = (op_ff == OP_APPEND) || !any_eq;

   assign req_ch.ready            = (state_ff == STATE_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.term_coefficient = rsp_term_ff.coef;
   assign rsp_ch.term_exponent    = rsp_term_ff.expo;
   assign rsp_ch.last             = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_term_in   = rsp_term_ff;
      rsp_last_in   = rsp_last_ff;
      cmd           = '0;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_ch.valid) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (slot_free) begin
               unique case (op_ff) inside
                  OP_APPEND, OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_term_in  = '0;
                     rsp_last_in  = 1'b1;
                     cmd.merge    = (op_ff == OP_ADD);
                     if (needs_entry && full) begin
                        rsp_status_in = STATUS_DROPPED;
                     end else begin
                        rsp_status_in = STATUS_ACCEPTED;
                     end
                     if (needs_entry && !full) begin
                        cmd.insert = 1'b1;
                        count_in   = count_ff + 1'b1;
                     end
                     state_in = STATE_IDLE;
                  end
                  OP_EMIT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_term_in   = '0;
                        rsp_last_in   = 1'b1;
                        state_in      = STATE_IDLE;
                     end else begin
                        state_in = STATE_DRAIN;
                     end
                  end
                  default: begin
                     state_in = STATE_IDLE;
                  end
               endcase
            end
         end
         STATE_DRAIN: begin
            if (slot_free) begin
               // head cell is the largest exponent; the chain shifts toward it
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_EMITTED;
               rsp_term_in   = terms[0];
               rsp_last_in   = (count_ff == CW'(1));
               cmd.drain     = 1'b1;
               count_in      = count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  state_in = STATE_IDLE;
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         op_ff        <= req_ch.opcode;
         item_ff.coef <= req_ch.coefficient;
         item_ff.expo <= req_ch.exponent;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_term_ff   <= rsp_term_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

FILE: rtl/spt_checker.sv
// port-level checks for the sparse polynomial term merger, bound to the top level
`timescale 1ns / 1ps

module spt_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input spt_pkg::status_type rsp_status,
   input logic                rsp_last
);
   import spt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ACCEPTED || rsp_status == STATUS_DROPPED ||
                    rsp_status == STATUS_EMPTY) |-> rsp_last)
      else $error("single-response status without last");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken again before the item was processed");

endmodule

bind sparse_polynomial_term_merger_unit spt_checker u_spt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_last   (rsp_ch.last)
);
